### hdl/jts_pkg.sv
// Shared types, character codes and result codes of the JSON token scanner.
package jts_pkg;

   localparam int POS_W   = 16;
   localparam int DEPTH_W = 6;
   localparam int Q_DEPTH = 4;

   localparam logic [2:0] ST_TOKEN    = 3'd0;
   localparam logic [2:0] ST_BAD_ROOT = 3'd1;
   localparam logic [2:0] ST_TOO_DEEP = 3'd2;
   localparam logic [2:0] ST_END      = 3'd3;
   localparam logic [2:0] ST_TOO_LONG = 3'd4;

   localparam logic [2:0] TT_STRING  = 3'd0;
   localparam logic [2:0] TT_OBJECT  = 3'd1;
   localparam logic [2:0] TT_ARRAY   = 3'd2;
   localparam logic [2:0] TT_BOOLEAN = 3'd3;
   localparam logic [2:0] TT_NULL    = 3'd4;
   localparam logic [2:0] TT_NUMBER  = 3'd5;

   localparam logic [2:0] SKIP_SHORT = 3'd3;
   localparam logic [2:0] SKIP_LONG  = 3'd4;

   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_TAB    = 8'h09;

   typedef struct packed {
      logic [2:0]         status;
      logic [2:0]         token_type;
      logic [POS_W-1:0]   start_pos;
      logic [POS_W-1:0]   end_pos;
      logic [DEPTH_W-1:0] depth;
   } result_type;

   typedef struct packed {
      result_type first;
      result_type second;
      logic       two;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } qlink_type;

   function automatic logic is_space(logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_LF) || (c == CH_CR) || (c == CH_TAB);
   endfunction

endpackage

### hdl/jts_req_if.sv
// Byte input channel of the JSON token scanner.
interface jts_req_if import jts_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

### hdl/jts_rsp_if.sv
// Token result channel of the JSON token scanner.
interface jts_rsp_if import jts_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic [2:0]         token_type;
   logic [POS_W-1:0]   start_pos;
   logic [POS_W-1:0]   end_pos;
   logic [DEPTH_W-1:0] depth;

   modport source (output valid, output status, output token_type, output start_pos,
                   output end_pos, output depth, input ready);
   modport sink (input valid, input status, input token_type, input start_pos,
                 input end_pos, input depth, output ready);
endinterface

### hdl/jts_front.sv
// Front end: accepts text bytes, tracks scan state and builds result entries.
module jts_front import jts_pkg::*; #(
   parameter int MAX_DEPTH = 32,
   parameter int POS_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   jts_req_if.sink     req,
   input  logic        push_ready,
   output qlink_type   push
);

   localparam int LVL_W  = $clog2(MAX_DEPTH + 1);
   localparam int IDX_W  = $clog2(MAX_DEPTH);
   localparam int PCNT_W = POS_BITS + 1;
   localparam logic [LVL_W-1:0] MAX_LVL = LVL_W'(MAX_DEPTH);

   localparam logic [2:0] M_ROOT = 3'd0;
   localparam logic [2:0] M_SCAN = 3'd1;
   localparam logic [2:0] M_STR  = 3'd2;
   localparam logic [2:0] M_ESC  = 3'd3;
   localparam logic [2:0] M_NUM  = 3'd4;
   localparam logic [2:0] M_SKIP = 3'd5;
   localparam logic [2:0] M_HALT = 3'd6;

   logic [2:0]          mode_ff, mode_in;
   logic [2:0]          skip_ff, skip_in;
   logic [PCNT_W-1:0]   pos_ff, pos_in;
   logic [LVL_W-1:0]    lvl_ff, lvl_in;
   logic [MAX_DEPTH-1:0] marks_ff, marks_in;
   logic [POS_BITS-1:0] tstart_ff, tstart_in;
   logic                pend_ff, pend_in;

   logic                accept;
   logic                run_scan;
   logic                num_v, oth_v;
   result_type          num_r, oth_r;

   logic                pp, pop1, pop2;
   logic [LVL_W-1:0]    lvl_m1, l1, l1_m1, l2, l2_m1, l3;
   logic [2:0]          lit_skip;
   logic [POS_BITS-1:0] lit_end;
   logic [PCNT_W-1:0]   pos_m1;

   logic [PCNT_W+POS_W-1:0]   pos_x, pos_m1_x;
   logic [POS_BITS+POS_W-1:0] tstart_x, lit_end_x;
   logic [LVL_W+DEPTH_W-1:0]  lvl_x, l1_x;
   logic [POS_W-1:0]          pos_o, pos_m1_o, tstart_o, lit_end_o;
   logic [DEPTH_W-1:0]        lvl_o, l1_o;

   assign accept   = req.valid & req.ready;
   assign req.ready = push_ready;

   assign pp     = (mode_ff == M_NUM) | pend_ff;
   assign lvl_m1 = lvl_ff - LVL_W'(1);
   assign pop1   = pp && (lvl_ff != '0) && marks_ff[lvl_m1[IDX_W-1:0]];
   assign l1     = pop1 ? lvl_m1 : lvl_ff;
   assign l1_m1  = l1 - LVL_W'(1);
   assign l2     = l1_m1;
   assign l2_m1  = l2 - LVL_W'(1);
   assign pop2   = (l2 != '0) && marks_ff[l2_m1[IDX_W-1:0]];
   assign l3     = pop2 ? l2_m1 : l2;

   assign lit_skip = (req.text_byte == CH_LOW_F) ? SKIP_LONG : SKIP_SHORT;
   assign lit_end  = pos_ff[POS_BITS-1:0] + POS_BITS'(lit_skip);
   assign pos_m1   = pos_ff - PCNT_W'(1);

   assign pos_x     = {{POS_W{1'b0}}, pos_ff};
   assign pos_m1_x  = {{POS_W{1'b0}}, pos_m1};
   assign tstart_x  = {{POS_W{1'b0}}, tstart_ff};
   assign lit_end_x = {{POS_W{1'b0}}, lit_end};
   assign lvl_x     = {{DEPTH_W{1'b0}}, lvl_ff};
   assign l1_x      = {{DEPTH_W{1'b0}}, l1};
   assign pos_o     = pos_x[POS_W-1:0];
   assign pos_m1_o  = pos_m1_x[POS_W-1:0];
   assign tstart_o  = tstart_x[POS_W-1:0];
   assign lit_end_o = lit_end_x[POS_W-1:0];
   assign lvl_o     = lvl_x[DEPTH_W-1:0];
   assign l1_o      = l1_x[DEPTH_W-1:0];

   always_comb begin
      mode_in   = mode_ff;
      skip_in   = skip_ff;
      pos_in    = pos_ff;
      lvl_in    = lvl_ff;
      marks_in  = marks_ff;
      tstart_in = tstart_ff;
      pend_in   = pend_ff;
      run_scan  = 1'b0;
      num_v     = 1'b0;
      oth_v     = 1'b0;
      num_r     = '{ST_TOKEN, TT_NUMBER, tstart_o, pos_m1_o, lvl_o};
      oth_r     = '{ST_TOKEN, TT_STRING, pos_o, pos_o, lvl_o};
      if (accept) begin
         if (req.end_of_text) begin
            if (mode_ff != M_HALT) begin
               num_v = (mode_ff == M_NUM);
               oth_v = 1'b1;
               oth_r.status = (mode_ff == M_ROOT) ? ST_BAD_ROOT : ST_END;
            end
            mode_in   = M_ROOT;
            skip_in   = '0;
            pos_in    = '0;
            lvl_in    = '0;
            marks_in  = '0;
            tstart_in = '0;
            pend_in   = 1'b0;
         end else if (mode_ff != M_HALT) begin
            if (pos_ff[POS_BITS]) begin
               oth_v        = 1'b1;
               oth_r.status = ST_TOO_LONG;
               mode_in      = M_HALT;
            end else begin
               case (mode_ff)
                  M_ROOT: begin
                     if (req.text_byte == CH_LBRACE || req.text_byte == CH_LBRACK) begin
                        oth_v = 1'b1;
                        oth_r.token_type = (req.text_byte == CH_LBRACE) ? TT_OBJECT : TT_ARRAY;
                        oth_r.depth = '0;
                        lvl_in   = LVL_W'(1);
                        marks_in = '0;
                        mode_in  = M_SCAN;
                     end else if (!is_space(req.text_byte)) begin
                        oth_v        = 1'b1;
                        oth_r.status = ST_BAD_ROOT;
                        mode_in      = M_HALT;
                     end
                  end
                  M_SCAN: begin
                     run_scan = 1'b1;
                  end
                  M_STR: begin
                     if (req.text_byte == CH_BSLASH) begin
                        mode_in = M_ESC;
                     end else if (req.text_byte == CH_QUOTE) begin
                        oth_v = 1'b1;
                        oth_r.start_pos = tstart_o;
                        pend_in = 1'b1;
                        mode_in = M_SCAN;
                     end
                  end
                  M_ESC: begin
                     mode_in = M_STR;
                  end
                  M_NUM: begin
                     if (is_space(req.text_byte) || req.text_byte == CH_RBRACE ||
                         req.text_byte == CH_RBRACK || req.text_byte == CH_COMMA) begin
                        num_v    = 1'b1;
                        mode_in  = M_SCAN;
                        run_scan = 1'b1;
                     end
                  end
                  M_SKIP: begin
                     skip_in = (skip_ff != '0) ? skip_ff - 3'd1 : skip_ff;
                     if (skip_in == '0) begin
                        mode_in = M_SCAN;
                     end
                  end
                  default: begin
                     mode_in = M_HALT;
                  end
               endcase
               if (run_scan) begin
                  pend_in = 1'b0;
                  lvl_in  = l1;
                  case (req.text_byte)
                     CH_RBRACE, CH_RBRACK: begin
                        if (l1 != '0) begin
                           lvl_in = l3;
                        end
                     end
                     CH_COLON, CH_LBRACE, CH_LBRACK: begin
                        if (l1 >= MAX_LVL) begin
                           oth_v        = 1'b1;
                           oth_r.status = ST_TOO_DEEP;
                           oth_r.depth  = l1_o;
                           mode_in      = M_HALT;
                        end else begin
                           if (req.text_byte == CH_COLON) begin
                              marks_in[l1[IDX_W-1:0]] = 1'b1;
                           end else begin
                              oth_v = 1'b1;
                              oth_r.token_type =
                                 (req.text_byte == CH_LBRACE) ? TT_OBJECT : TT_ARRAY;
                              oth_r.depth = l1_o;
                              marks_in[l1[IDX_W-1:0]] = 1'b0;
                           end
                           lvl_in = l1 + LVL_W'(1);
                        end
                     end
                     CH_LOW_N, CH_LOW_T, CH_LOW_F: begin
                        skip_in = lit_skip;
                        oth_v   = 1'b1;
                        oth_r.token_type = (req.text_byte == CH_LOW_N) ? TT_NULL : TT_BOOLEAN;
                        oth_r.end_pos    = lit_end_o;
                        oth_r.depth      = l1_o;
                        mode_in = M_SKIP;
                        pend_in = 1'b1;
                     end
                     CH_QUOTE: begin
                        tstart_in = pos_ff[POS_BITS-1:0];
                        mode_in   = M_STR;
                     end
                     default: begin
                        if (req.text_byte == CH_MINUS ||
                            (req.text_byte >= CH_ZERO && req.text_byte <= CH_NINE)) begin
                           tstart_in = pos_ff[POS_BITS-1:0];
                           mode_in   = M_NUM;
                        end
                     end
                  endcase
               end
               if (mode_in != M_HALT) begin
                  pos_in = pos_ff + PCNT_W'(1);
               end
            end
         end
      end
   end

   always_comb begin
      push.valid        = accept & (num_v | oth_v);
      push.entry.first  = num_v ? num_r : oth_r;
      push.entry.second = oth_r;
      push.entry.two    = num_v & oth_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= M_ROOT;
         skip_ff   <= '0;
         pos_ff    <= '0;
         lvl_ff    <= '0;
         marks_ff  <= '0;
         tstart_ff <= '0;
         pend_ff   <= 1'b0;
      end else begin
         mode_ff   <= mode_in;
         skip_ff   <= skip_in;
         pos_ff    <= pos_in;
         lvl_ff    <= lvl_in;
         marks_ff  <= marks_in;
         tstart_ff <= tstart_in;
         pend_ff   <= pend_in;
      end
   end

endmodule

### hdl/jts_queue.sv
// Short result-entry queue between the front end and the back end.
module jts_queue import jts_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  qlink_type push,
   output logic      push_ready,
   output qlink_type head,
   input  logic      pop
);

   localparam int QP_W = $clog2(Q_DEPTH);
   localparam int QC_W = $clog2(Q_DEPTH + 1);

   entry_type        entries_ff [Q_DEPTH];
   logic [QP_W-1:0]  wr_ff, wr_in;
   logic [QP_W-1:0]  rd_ff, rd_in;
   logic [QC_W-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != QC_W'(Q_DEPTH));
   assign do_push    = push.valid & push_ready;
   assign do_pop     = pop & (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.entry = entries_ff[rd_ff];

   always_comb begin
      wr_in    = do_push ? wr_ff + QP_W'(1) : wr_ff;
      rd_in    = do_pop ? rd_ff + QP_W'(1) : rd_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QC_W'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - QC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ff] <= push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

### hdl/jts_back.sv
// Back end: unpacks queue entries and drives the registered result channel.
module jts_back import jts_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  qlink_type head,
   output logic      pop,
   jts_rsp_if.source rsp
);

   logic       out_v_ff, out_v_in;
   result_type out_ff, out_in;
   logic       pend_v_ff, pend_v_in;
   result_type pend_ff, pend_in;
   logic       out_free;

   assign out_free = !out_v_ff | rsp.ready;
   assign pop      = !pend_v_ff & head.valid & out_free;

   always_comb begin
      out_v_in  = out_v_ff;
      out_in    = out_ff;
      pend_v_in = pend_v_ff;
      pend_in   = pend_ff;
      if (out_free) begin
         if (pend_v_ff) begin
            out_in    = pend_ff;
            out_v_in  = 1'b1;
            pend_v_in = 1'b0;
         end else if (head.valid) begin
            out_in    = head.entry.first;
            out_v_in  = 1'b1;
            pend_in   = head.entry.second;
            pend_v_in = head.entry.two;
         end else begin
            out_v_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      pend_ff <= pend_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         pend_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         pend_v_ff <= pend_v_in;
      end
   end

   assign rsp.valid      = out_v_ff;
   assign rsp.status     = out_ff.status;
   assign rsp.token_type = out_ff.token_type;
   assign rsp.start_pos  = out_ff.start_pos;
   assign rsp.end_pos    = out_ff.end_pos;
   assign rsp.depth      = out_ff.depth;

endmodule

### hdl/json_token_scanner.sv
// JSON token scanner: one text byte in per transaction, one token or status out.
//
// req_chan carries text_byte and end_of_text; a transaction with end_of_text
// high closes the text and carries no character. rsp_chan gives one
// transaction per token (type, first and last offset, depth) or per status
// event (bad root, too deep, end of text, text too long).
// Throughput: one byte per cycle while the queue has room. A byte yields
// zero, one or two results; two results leave rsp_chan one after the
// other, and the four-entry queue between the byte front end and the
// result back end absorbs such bursts. A result is written to the queue at
// the accepting edge, then goes through the output register to rsp_chan.
// Reset clears the scan state, the queue and the output register; the block
// then waits for a root container. When rsp_chan stalls, results hold in the
// output register and the queue; req_chan.ready drops only once the queue is
// full, and the scan state advances only on accepted transactions.
module json_token_scanner import jts_pkg::*; #(
   parameter int MAX_DEPTH = 32,
   parameter int POS_BITS  = 16
) (
   input  logic      clock,
   input  logic      reset,
   jts_req_if.sink   req_chan,
   jts_rsp_if.source rsp_chan
);

   qlink_type push;
   qlink_type head;
   logic      push_ready;
   logic      pop;

   jts_front #(
      .MAX_DEPTH (MAX_DEPTH),
      .POS_BITS  (POS_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .push_ready (push_ready),
      .push       (push)
   );

   jts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .head       (head),
      .pop        (pop)
   );

   jts_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp_chan)
   );

endmodule
